>>> hw/rtl/best_fit_block_allocator_assert.svh
// Assertion macros for the best-fit block allocator.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define BFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Condition must never be true outside reset.
`define BFA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/bfa_pkg.sv
// Package for the best-fit block allocator: sizes, codes and shared types.
// Used by bfa_cell and best_fit_block_allocator; depends on nothing.
package bfa_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int SIZE_BITS   = 16;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths of the stream items.
    localparam int OP_BITS     = 2;
    localparam int AMT_BITS    = 16;
    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = 4;
    localparam int LEFT_BITS   = 16;
    localparam int USED_BITS   = 5;
    localparam int IN_BITS     = 24;
    localparam int OUT_BITS    = 32;

    // Compare width that holds both a stored size and a request.
    localparam int CMP_BITS = (SIZE_BITS > AMT_BITS) ? SIZE_BITS : AMT_BITS;

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(MAX_ENTRIES);

    // Operation codes.
    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ALLOC  = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        STS_ALLOCATED  = 3'd0,
        STS_NO_FIT     = 3'd1,
        STS_APPENDED   = 3'd2,
        STS_TABLE_FULL = 3'd3,
        STS_CLEARED    = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_RESP
    } fsm_state_t;

    // Update command broadcast to every cell.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_APPEND,
        CMD_ALLOC
    } cell_cmd_t;

    // Broadcast control bundle from the controller to the cell row.
    typedef struct packed {
        cell_cmd_t            cmd;
        logic [AMT_BITS-1:0]  amount;
        logic [IDX_BITS-1:0]  best;
        logic                 split;
        logic [SIZE_BITS-1:0] remaining;
        logic [CNT_BITS-1:0]  count;
    } cell_ctrl_t;

    // Running best-fit candidate handed from cell to cell.
    typedef struct packed {
        logic                 found;
        logic [SIZE_BITS-1:0] size;
        logic [IDX_BITS-1:0]  idx;
    } srch_t;

    // Input item layout on s_tdata.
    typedef struct packed {
        logic [IN_BITS-OP_BITS-AMT_BITS-1:0] pad;
        logic [AMT_BITS-1:0]                 amount;
        logic [OP_BITS-1:0]                  op;
    } in_item_t;

    // Result item layout on m_tdata.
    typedef struct packed {
        logic [OUT_BITS-STATUS_BITS-SLOT_BITS-LEFT_BITS-1-USED_BITS-1:0] pad;
        logic [USED_BITS-1:0]  used_entries;
        logic                  did_split;
        logic [LEFT_BITS-1:0]  leftover;
        logic [SLOT_BITS-1:0]  slot;
        status_t               status;
    } out_item_t;

endpackage

>>> hw/rtl/bfa_cell.sv
// One table cell of the best-fit block allocator: an entry's size and free
// mark, plus one stage of the best-fit search chain. Depends on bfa_pkg.
module bfa_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfa_pkg::IDX_BITS-1:0]  cell_idx,
    input  bfa_pkg::cell_ctrl_t           ctrl,
    input  logic [bfa_pkg::SIZE_BITS-1:0] left_size,
    input  logic                          left_free,
    input  bfa_pkg::srch_t                left_srch,
    output logic [bfa_pkg::SIZE_BITS-1:0] size,
    output logic                          free,
    output bfa_pkg::srch_t                srch
);

    logic [bfa_pkg::SIZE_BITS-1:0] size_reg;
    logic [bfa_pkg::SIZE_BITS-1:0] size_next;
    logic                          free_reg;
    logic                          free_next;
    bfa_pkg::srch_t                srch_reg;
    bfa_pkg::srch_t                srch_next;
    logic                          active;
    logic                          cand;
    logic [bfa_pkg::IDX_BITS:0]    idx_ext;
    logic [bfa_pkg::IDX_BITS:0]    best_after;

    // Search stage: take over the candidate if this entry fits more tightly.
    // A strict compare keeps the lower index on a tie.
    always_comb
    begin
        active = bfa_pkg::CNT_BITS'(cell_idx) < ctrl.count;
        cand   = active && free_reg &&
                 (bfa_pkg::CMP_BITS'(size_reg) >= bfa_pkg::CMP_BITS'(ctrl.amount));
        if (cand && (!left_srch.found || (size_reg < left_srch.size)))
        begin
            srch_next.found = 1'b1;
            srch_next.size  = size_reg;
            srch_next.idx   = cell_idx;
        end
        else
        begin
            srch_next = left_srch;
        end
    end

    // Entry update for append, allocate and the shift that opens a split slot.
    always_comb
    begin
        idx_ext    = {1'b0, cell_idx};
        best_after = {1'b0, ctrl.best} + 1'b1;
        size_next  = size_reg;
        free_next  = free_reg;
        case (ctrl.cmd)
            bfa_pkg::CMD_APPEND:
            begin
                if (cell_idx == bfa_pkg::IDX_BITS'(ctrl.count))
                begin
                    size_next = bfa_pkg::SIZE_BITS'(ctrl.amount);
                    free_next = 1'b1;
                end
            end
            bfa_pkg::CMD_ALLOC:
            begin
                if (cell_idx == ctrl.best)
                begin
                    free_next = 1'b0;
                    if (ctrl.split)
                    begin
                        size_next = bfa_pkg::SIZE_BITS'(ctrl.amount);
                    end
                end
                else if (ctrl.split && (idx_ext == best_after))
                begin
                    size_next = ctrl.remaining;
                    free_next = 1'b1;
                end
                else if (ctrl.split && (idx_ext > best_after))
                begin
                    size_next = left_size;
                    free_next = left_free;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Entry storage holds no reset value; only written entries are read.
    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        free_reg <= free_next;
    end

    // Search candidate register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign size = size_reg;
    assign free = free_reg;
    assign srch = srch_reg;

endmodule

>>> hw/rtl/best_fit_block_allocator.sv
// Best-fit block allocator: a row of table cells and the controller that
// sequences search and update. Depends on bfa_pkg, bfa_cell and the assert header.
//
// Usage: one item enters on the s_ stream (op and amount) and exactly one
// result leaves on the m_ stream (status, slot, leftover, did_split and
// used_entries). Items are taken one at a time.
// Sequence: a clear, an append or an unused op code moves from idle to the
// response state, which registers its result once the output register is
// free. An allocation first passes through the search state, in which the
// best-fit candidate walks the cell row one cell per clock; the response
// state then applies the update with any shift of the entries behind the
// winner and registers the result. The next item is taken in the cycle
// after the result is registered.
// Reset clears the entry count, the controller and the output valid flag; the
// table contents are left as they are and are never read before written.
// A stalled receiver holds the result in the output register; the block may
// take one further item meanwhile but holds its result until the output
// register is free.
`include "best_fit_block_allocator_assert.svh"

module best_fit_block_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0 up: op[1:0], amount[17:2], zero pad[23:18].
    input  logic [bfa_pkg::IN_BITS-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0 up: status[2:0], slot[6:3], leftover[22:7],
    // did_split[23], used_entries[28:24], zero pad[31:29].
    output logic [bfa_pkg::OUT_BITS-1:0] m_tdata
);

    localparam int N = bfa_pkg::MAX_ENTRIES;

    bfa_pkg::fsm_state_t            state_reg;
    bfa_pkg::fsm_state_t            state_next;
    logic [bfa_pkg::IDX_BITS-1:0]   cnt_reg;
    logic [bfa_pkg::IDX_BITS-1:0]   cnt_next;
    logic [bfa_pkg::OP_BITS-1:0]    op_reg;
    logic [bfa_pkg::OP_BITS-1:0]    op_next;
    logic [bfa_pkg::AMT_BITS-1:0]   amount_reg;
    logic [bfa_pkg::AMT_BITS-1:0]   amount_next;
    logic [bfa_pkg::CNT_BITS-1:0]   count_reg;
    logic [bfa_pkg::CNT_BITS-1:0]   count_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    bfa_pkg::out_item_t             res_reg;
    bfa_pkg::out_item_t             res_next;

    bfa_pkg::in_item_t              in_item;
    bfa_pkg::cell_ctrl_t            ctrl;
    bfa_pkg::srch_t                 best;
    logic                           out_free;
    logic [bfa_pkg::CMP_BITS-1:0]   diff;
    logic [bfa_pkg::SIZE_BITS-1:0]  remaining;
    logic                           split;

    logic [bfa_pkg::SIZE_BITS-1:0]  size_w [N];
    logic                           free_w [N];
    bfa_pkg::srch_t                 srch_w [N];

    assign in_item = s_tdata;

    // Row of cells; each hands its entry and search candidate to the next.
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            bfa_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (bfa_pkg::IDX_BITS'(g)),
                .ctrl      (ctrl),
                .left_size ('0),
                .left_free (1'b0),
                .left_srch ('0),
                .size      (size_w[g]),
                .free      (free_w[g]),
                .srch      (srch_w[g])
            );
        end
        else
        begin : g_rest
            bfa_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (bfa_pkg::IDX_BITS'(g)),
                .ctrl      (ctrl),
                .left_size (size_w[g-1]),
                .left_free (free_w[g-1]),
                .left_srch (srch_w[g-1]),
                .size      (size_w[g]),
                .free      (free_w[g]),
                .srch      (srch_w[g])
            );
        end
    end

    // The last cell holds the winner once the search has run the full row.
    assign best = srch_w[N-1];

    // Remainder of the winning entry and whether it splits.
    always_comb
    begin
        diff      = bfa_pkg::CMP_BITS'(best.size) - bfa_pkg::CMP_BITS'(amount_reg);
        remaining = bfa_pkg::SIZE_BITS'(diff);
        split     = (remaining != '0) && (count_reg < bfa_pkg::FULL_COUNT);
    end

    // Next state, cell commands and result formation.
    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        amount_next    = amount_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_next       = res_reg;
        s_tready       = 1'b0;

        ctrl.cmd       = bfa_pkg::CMD_NONE;
        ctrl.amount    = amount_reg;
        ctrl.best      = best.idx;
        ctrl.split     = split;
        ctrl.remaining = remaining;
        ctrl.count     = count_reg;

        case (state_reg)
            bfa_pkg::FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = in_item.op;
                    amount_next = in_item.amount;
                    cnt_next    = '0;
                    if (in_item.op == bfa_pkg::OP_ALLOC)
                    begin
                        state_next = bfa_pkg::FSM_SEARCH;
                    end
                    else
                    begin
                        state_next = bfa_pkg::FSM_RESP;
                    end
                end
            end
            bfa_pkg::FSM_SEARCH:
            begin
                if (cnt_reg == bfa_pkg::IDX_BITS'(N - 1))
                begin
                    state_next = bfa_pkg::FSM_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bfa_pkg::FSM_RESP:
            begin
                if (out_free)
                begin
                    res_next           = '0;
                    res_next.status    = bfa_pkg::STS_NO_FIT;
                    case (op_reg)
                        bfa_pkg::OP_CLEAR:
                        begin
                            count_next      = '0;
                            res_next.status = bfa_pkg::STS_CLEARED;
                        end
                        bfa_pkg::OP_APPEND:
                        begin
                            if (count_reg >= bfa_pkg::FULL_COUNT)
                            begin
                                res_next.status = bfa_pkg::STS_TABLE_FULL;
                            end
                            else
                            begin
                                ctrl.cmd        = bfa_pkg::CMD_APPEND;
                                count_next      = count_reg + 1'b1;
                                res_next.status = bfa_pkg::STS_APPENDED;
                                res_next.slot   = bfa_pkg::SLOT_BITS'(count_reg);
                            end
                        end
                        bfa_pkg::OP_ALLOC:
                        begin
                            if (best.found)
                            begin
                                ctrl.cmd        = bfa_pkg::CMD_ALLOC;
                                res_next.status = bfa_pkg::STS_ALLOCATED;
                                res_next.slot   = bfa_pkg::SLOT_BITS'(best.idx);
                                if (split)
                                begin
                                    count_next         = count_reg + 1'b1;
                                    res_next.leftover  =
                                        bfa_pkg::LEFT_BITS'(remaining);
                                    res_next.did_split = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.used_entries = bfa_pkg::USED_BITS'(count_next);
                    out_valid_next        = 1'b1;
                    state_next            = bfa_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::FSM_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        amount_reg <= amount_next;
        res_reg    <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Checks on the controller and the entry count.
    `BFA_ASSERT_NEVER(a_count_range, count_reg > bfa_pkg::FULL_COUNT, "entry count above table size")
    `BFA_ASSERT(a_count_step, (count_reg != $past(count_reg)) |-> ((count_reg == $past(count_reg) + 1'b1) || (count_reg == '0)), "entry count moved by more than one")
    `BFA_ASSERT(a_count_in_resp, (count_reg != $past(count_reg)) |-> $past(state_reg == bfa_pkg::FSM_RESP), "entry count changed outside the update step")
    `BFA_ASSERT(a_result_from_resp, $rose(m_tvalid) |-> $past(state_reg == bfa_pkg::FSM_RESP), "result shown without an update step")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for best_fit_block_allocator: stream driver, stream monitor
// and a best-fit table predictor that checks every result transfer field by field.
// Depends on bfa_pkg and the best_fit_block_allocator RTL.
`timescale 1ns / 100ps

module tb_top;

    // Op code that the block does not decode; it must answer as no fit.
    localparam logic [bfa_pkg::OP_BITS-1:0] OP_RESERVED = 2'd3;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = bfa_pkg::MAX_ENTRIES + 8;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [bfa_pkg::IN_BITS-1:0]  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [bfa_pkg::OUT_BITS-1:0] m_tdata;

    // Requests waiting for the driver and results waiting for the monitor.
    bfa_pkg::in_item_t  pending_requests[$];
    bfa_pkg::out_item_t pending_results[$];

    int total_items = 1;
    int accepted_cnt = 0;
    int mismatch_cnt = 0;

    // Predictor copy of the block table.
    logic [bfa_pkg::SIZE_BITS-1:0] blk_size [bfa_pkg::MAX_ENTRIES];
    logic                          blk_free [bfa_pkg::MAX_ENTRIES];
    int                            blk_count = 0;

    best_fit_block_allocator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard limit on the run length.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Builds one request with the pad bits cleared and queues it.
    function automatic void push_request(logic [bfa_pkg::OP_BITS-1:0] op,
                                         logic [bfa_pkg::AMT_BITS-1:0] amount);
        bfa_pkg::in_item_t req;
        req = '0;
        req.op = op;
        req.amount = amount;
        pending_requests.push_back(req);
    endfunction

    function automatic logic [bfa_pkg::AMT_BITS-1:0] pick_size(int mode);
        case (mode)
            0:       return bfa_pkg::AMT_BITS'($urandom_range(31));
            1:       return bfa_pkg::AMT_BITS'($urandom_range(1023));
            default: return bfa_pkg::AMT_BITS'($urandom_range(65535));
        endcase
    endfunction

    // Applies one request to the table copy and returns the result it must give.
    function automatic bfa_pkg::out_item_t predict_allocation(bfa_pkg::in_item_t req);
        bfa_pkg::out_item_t            res;
        int                            best;
        bit                            found;
        logic [bfa_pkg::SIZE_BITS-1:0] remaining;
        res = '0;
        best = 0;
        found = 1'b0;
        case (req.op)
            bfa_pkg::OP_CLEAR:
            begin
                blk_count = 0;
                res.status = bfa_pkg::STS_CLEARED;
            end
            bfa_pkg::OP_APPEND:
            begin
                if (blk_count >= bfa_pkg::MAX_ENTRIES)
                begin
                    res.status = bfa_pkg::STS_TABLE_FULL;
                end
                else
                begin
                    blk_size[blk_count] = req.amount;
                    blk_free[blk_count] = 1'b1;
                    res.status = bfa_pkg::STS_APPENDED;
                    res.slot = bfa_pkg::SLOT_BITS'(blk_count);
                    blk_count++;
                end
            end
            bfa_pkg::OP_ALLOC:
            begin
                // Smallest free entry that fits; the strict compare keeps the lowest index.
                for (int i = 0; i < blk_count; i++)
                begin
                    if (blk_free[i] && blk_size[i] >= req.amount &&
                        (!found || blk_size[i] < blk_size[best]))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    res.status = bfa_pkg::STS_NO_FIT;
                end
                else
                begin
                    blk_free[best] = 1'b0;
                    remaining = blk_size[best] - req.amount;
                    res.status = bfa_pkg::STS_ALLOCATED;
                    res.slot = bfa_pkg::SLOT_BITS'(best);
                    // Split only when something is left and a free slot exists.
                    if (remaining != 0 && blk_count < bfa_pkg::MAX_ENTRIES)
                    begin
                        for (int i = blk_count; i > best + 1; i--)
                        begin
                            blk_size[i] = blk_size[i - 1];
                            blk_free[i] = blk_free[i - 1];
                        end
                        blk_size[best] = req.amount;
                        blk_size[best + 1] = remaining;
                        blk_free[best + 1] = 1'b1;
                        blk_count++;
                        res.leftover = remaining;
                        res.did_split = 1'b1;
                    end
                end
            end
            default:
            begin
                res.status = bfa_pkg::STS_NO_FIT;
            end
        endcase
        res.used_entries = bfa_pkg::USED_BITS'(blk_count);
        return res;
    endfunction

    // Idle phase: 0 sender light and receiver heavy, 1 the reverse, 2 no idling.
    function automatic int idle_phase();
        return (accepted_cnt * 3) / total_items;
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int mode;
        int n_app;
        int n_alloc;
        int pick;

        // Directed part: empty table, zero sizes, ties, splits, full table.
        push_request(bfa_pkg::OP_CLEAR, 16'd0);
        push_request(bfa_pkg::OP_ALLOC, 16'd0);
        push_request(OP_RESERVED, 16'hFFFF);
        push_request(bfa_pkg::OP_APPEND, 16'd0);
        push_request(bfa_pkg::OP_ALLOC, 16'd0);
        push_request(bfa_pkg::OP_APPEND, 16'hFFFF);
        push_request(bfa_pkg::OP_APPEND, 16'd100);
        push_request(bfa_pkg::OP_APPEND, 16'd100);
        push_request(bfa_pkg::OP_ALLOC, 16'd60);
        push_request(bfa_pkg::OP_ALLOC, 16'd0);
        push_request(bfa_pkg::OP_ALLOC, 16'hFFFF);
        push_request(bfa_pkg::OP_ALLOC, 16'hFFFF);
        push_request(bfa_pkg::OP_CLEAR, 16'd0);
        for (int k = 0; k < bfa_pkg::MAX_ENTRIES; k++)
        begin
            push_request(bfa_pkg::OP_APPEND, bfa_pkg::AMT_BITS'(3 * k + 1));
        end
        push_request(bfa_pkg::OP_APPEND, 16'hAAAA);
        push_request(bfa_pkg::OP_ALLOC, 16'd2);

        // Random part: fill a table, then allocate from it with some noise mixed in.
        total_items = pending_requests.size() + RANDOM_ITEMS;
        while (pending_requests.size() < total_items)
        begin
            mode = $urandom_range(2);
            if ($urandom_range(3) != 0)
            begin
                push_request(bfa_pkg::OP_CLEAR, pick_size(2));
            end
            n_app = $urandom_range(18, 1);
            for (int k = 0; k < n_app; k++)
            begin
                push_request(bfa_pkg::OP_APPEND, pick_size(mode));
            end
            n_alloc = $urandom_range(20, 2);
            for (int k = 0; k < n_alloc; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    push_request(OP_RESERVED, pick_size(2));
                end
                else if (pick < 12)
                begin
                    push_request(bfa_pkg::OP_APPEND, pick_size(mode));
                end
                else
                begin
                    push_request(bfa_pkg::OP_ALLOC, pick_size(mode) >> $urandom_range(2));
                end
            end
        end
        total_items = pending_requests.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to go in and every result to come out.
        while (accepted_cnt < total_items || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Request driver: predicts on each accepted transfer, then presents the next request.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        bit busy;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(predict_allocation(bfa_pkg::in_item_t'(s_tdata)));
                accepted_cnt++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= (idle_phase() == 0 ? 20 :
                                           idle_phase() == 1 ? 67 : 0))
                begin
                    s_tdata <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver back pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= $urandom_range(99) >= (idle_phase() == 0 ? 67 :
                                              idle_phase() == 1 ? 20 : 0);
        end
    end

    // Result monitor: each transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        bfa_pkg::out_item_t got;
        bfa_pkg::out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = bfa_pkg::out_item_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                begin
                    $display("Unexpected result transfer: status %0d slot %0d leftover %0d",
                             got.status, got.slot, got.leftover);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.slot != want.slot ||
                    got.leftover != want.leftover || got.did_split != want.did_split ||
                    got.used_entries != want.used_entries)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                    begin
                        $display("Result mismatch at %0t: expected status %0d slot %0d ",
                                 $realtime, want.status, want.slot,
                                 "leftover %0d split %0d used %0d", want.leftover,
                                 want.did_split, want.used_entries);
                        $display("    actual status %0d slot %0d leftover %0d split %0d used %0d",
                                 got.status, got.slot, got.leftover, got.did_split,
                                 got.used_entries);
                    end
                end
            end
        end
    end

endmodule
